// ===== sv/iprpl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// iprpl_pkg: widths, request codes and sequencer states for the ipv6 route lookup
// no dependencies

package iprpl_pkg;

    localparam int ROUTES     = 16;
    localparam int IDX_W      = $clog2(ROUTES);
    localparam int CNT_W      = $clog2(ROUTES + 1);
    localparam int CFG_W      = 5;
    localparam int ADDR_W     = 64;
    localparam int NET_W      = 2 * ADDR_W;
    localparam int LEN_W      = 8;
    localparam int IFACE_W    = 4;
    localparam logic [LEN_W-1:0] MAX_PREFIX = LEN_W'(128);

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_RESP
    } iprpl_state_t;

endpackage

`default_nettype wire

// ===== sv/iprpl_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// iprpl channel interfaces: request, result and configuration write
// depends on iprpl_pkg

interface iprpl_req_if
    import iprpl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [IDX_W-1:0]   entry_index;
    logic [ADDR_W-1:0]  addr_hi;
    logic [ADDR_W-1:0]  addr_lo;
    logic [LEN_W-1:0]   prefix_len;
    logic [IFACE_W-1:0] iface_in;

    modport source (
        output valid, req_type, entry_index, addr_hi, addr_lo, prefix_len, iface_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, addr_hi, addr_lo, prefix_len, iface_in,
        output ready
    );
endinterface

interface iprpl_rsp_if
    import iprpl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               found;
    logic [IFACE_W-1:0] out_iface;
    logic [LEN_W-1:0]   match_len;

    modport source (
        output valid, found, out_iface, match_len,
        input  ready
    );
    modport sink (
        input  valid, found, out_iface, match_len,
        output ready
    );
endinterface

interface iprpl_cfg_if
    import iprpl_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/ipv6_route_prefix_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ipv6_route_prefix_lookup: route table with longest prefix match scan
// depends on iprpl_pkg and the interfaces in iprpl_if
//
// channel  modport  payload
// req      sink     req_type, entry_index, addr_hi, addr_lo, prefix_len, iface_in
// rsp      source   found, out_iface, match_len
// cfg      sink     data (route_count)
//
// a route write gives no result
// a lookup scans n entries, n = min(route_count, 16), in ST_SCAN, then passes ST_FLUSH
// to ST_RESP, or goes straight to ST_RESP when n is zero: one table read per cycle
// through the single memory read port, one masked 128-bit compare
// the result is held until taken; req is not ready from a lookup until then
// rst_n clears route_count and the sequencer; the table itself is not cleared

module ipv6_route_prefix_lookup
    import iprpl_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    iprpl_req_if.sink   req,
    iprpl_rsp_if.source rsp,
    iprpl_cfg_if.sink   cfg
);

    logic [ADDR_W-1:0]  net_hi_mem [ROUTES];
    logic [ADDR_W-1:0]  net_lo_mem [ROUTES];
    logic [LEN_W-1:0]   prefix_mem [ROUTES];
    logic [IFACE_W-1:0] iface_mem  [ROUTES];

    iprpl_state_t       state_reg, state_next;
    logic [CFG_W-1:0]   route_count_reg;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic [CNT_W-1:0]   limit_reg, limit_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic               hit_reg, hit_next;
    logic [LEN_W-1:0]   best_len_reg, best_len_next;
    logic [IFACE_W-1:0] best_if_reg, best_if_next;

    logic [NET_W-1:0]   dest_reg;
    logic [NET_W-1:0]   rd_net_reg;
    logic [LEN_W-1:0]   rd_len_reg;
    logic [IFACE_W-1:0] rd_if_reg;

    logic               req_acc;
    logic               wr_acc;
    logic               lk_acc;
    logic [CNT_W-1:0]   count_clamped;
    logic [NET_W-1:0]   mask;
    logic               match;
    logic [LEN_W-1:0]   wr_len;

    assign req_acc = req.valid && req.ready;
    assign wr_acc  = req_acc && (req.req_type == REQ_WRITE);
    assign lk_acc  = req_acc && (req.req_type == REQ_LOOKUP);

    assign count_clamped = (CNT_W'(route_count_reg) > CNT_W'(ROUTES)) ?
                           CNT_W'(ROUTES) : CNT_W'(route_count_reg);

    assign wr_len = (req.prefix_len > MAX_PREFIX) ? MAX_PREFIX : req.prefix_len;

    // shared compare unit
    assign mask  = ~({NET_W{1'b1}} >> rd_len_reg);
    assign match = ((dest_reg ^ rd_net_reg) & mask) == '0;

    assign req.ready     = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign rsp.valid     = (state_reg == ST_RESP);
    assign rsp.found     = hit_reg;
    assign rsp.out_iface = best_if_reg;
    assign rsp.match_len = best_len_reg;

    always_ff @(posedge clk)
    begin
        if (wr_acc)
        begin
            net_hi_mem[req.entry_index] <= req.addr_hi;
            net_lo_mem[req.entry_index] <= req.addr_lo;
            prefix_mem[req.entry_index] <= wr_len;
            iface_mem[req.entry_index]  <= req.iface_in;
        end
        rd_net_reg <= {net_hi_mem[scan_reg[IDX_W-1:0]], net_lo_mem[scan_reg[IDX_W-1:0]]};
        rd_len_reg <= prefix_mem[scan_reg[IDX_W-1:0]];
        rd_if_reg  <= iface_mem[scan_reg[IDX_W-1:0]];
        if (lk_acc)
        begin
            dest_reg <= {req.addr_hi, req.addr_lo};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            route_count_reg <= '0;
            scan_reg        <= '0;
            limit_reg       <= '0;
            cmp_vld_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            best_len_reg    <= '0;
            best_if_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            limit_reg    <= limit_next;
            cmp_vld_reg  <= cmp_vld_next;
            hit_reg      <= hit_next;
            best_len_reg <= best_len_next;
            best_if_reg  <= best_if_next;
            if (cfg.valid && cfg.ready)
            begin
                route_count_reg <= cfg.data;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_next     = scan_reg;
        limit_next    = limit_reg;
        cmp_vld_next  = 1'b0;
        hit_next      = hit_reg;
        best_len_next = best_len_reg;
        best_if_next  = best_if_reg;

        // compare stage, first match of equal length is kept
        if (cmp_vld_reg && match && (!hit_reg || (rd_len_reg > best_len_reg)))
        begin
            hit_next      = 1'b1;
            best_len_next = rd_len_reg;
            best_if_next  = rd_if_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (lk_acc)
                begin
                    hit_next      = 1'b0;
                    best_len_next = '0;
                    best_if_next  = '0;
                    scan_next     = '0;
                    limit_next    = count_clamped;
                    state_next    = (count_clamped == '0) ? ST_RESP : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmp_vld_next = 1'b1;
                scan_next    = scan_reg + CNT_W'(1);
                if (scan_next == limit_reg)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.found |-> (rsp.out_iface == '0) && (rsp.match_len == '0))
        else $error("miss result carries non-zero fields");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.match_len <= MAX_PREFIX)
        else $error("match length above 128");

    a_busy_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        lk_acc |=> !req.ready)
        else $error("request taken while lookup in progress");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request ready while result pending");

endmodule

`default_nettype wire
